// ===== sv/hierarchical_bitmap_allocator_macros.svh =====
// assertion macros for the hierarchical bitmap allocator
`ifndef HIERARCHICAL_BITMAP_ALLOCATOR_MACROS_SVH
`define HIERARCHICAL_BITMAP_ALLOCATOR_MACROS_SVH

// same-cycle implication, checked on clk, quiet while arst_n is low
`define HBA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define HBA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/hba_pkg.sv =====
// package: constants, item types, command and status structs, helper functions
package hba_pkg;

	localparam int MAX_BLOCKS = 4096;
	localparam int MIN_BLOCKS = 2;
	localparam int WORD_BITS  = 64;
	localparam int BIT_W      = $clog2(WORD_BITS);
	localparam int LEAF_WORDS = MAX_BLOCKS / WORD_BITS;
	localparam int TREE_DEPTH = LEAF_WORDS + 1;
	localparam int WADDR_W    = $clog2(TREE_DEPTH);
	localparam int ADDR_W     = 12;
	localparam int CNT_W      = 13;

	typedef logic [WORD_BITS-1:0] word_t;

	typedef enum logic [1:0] {
		MODE_READ = 2'd0,
		MODE_USE  = 2'd1,
		MODE_FREE = 2'd2,
		MODE_FIND = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t             mode;
		logic [ADDR_W-1:0] block_addr;
	} req_item_t;

	typedef struct packed {
		logic              bit_value;
		logic              found;
		logic [ADDR_W-1:0] found_addr;
		logic [CNT_W-1:0]  free_count;
	} rsp_item_t;

	typedef struct packed {
		logic capture;
		logic rd_en;
		logic lvl2;
		logic ev1;
		logic ev2;
		logic load_out;
	} hba_cmd_t;

	typedef struct packed {
		logic             more;
		logic [CNT_W-1:0] n;
	} hba_sts_t;

	// index of the lowest clear bit, 63 when the word is all ones
	function automatic logic [BIT_W-1:0] lowest_zero(input word_t w);
		logic [2:0] byte_i;
		logic [2:0] bit_i;
		logic [7:0] b;
		byte_i = 3'd7;
		for (int k = 7; k >= 0; k--) begin
			if (w[k*8 +: 8] != 8'hFF) begin
				byte_i = 3'(k);
			end
		end
		b = w[byte_i*8 +: 8];
		bit_i = 3'd7;
		for (int k = 7; k >= 0; k--) begin
			if (!b[k]) begin
				bit_i = 3'(k);
			end
		end
		return {byte_i, bit_i};
	endfunction

	function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v);
		logic [CNT_W-1:0] r;
		r = v;
		if (v < CNT_W'(MIN_BLOCKS)) begin
			r = CNT_W'(MIN_BLOCKS);
		end else if (v > CNT_W'(MAX_BLOCKS)) begin
			r = CNT_W'(MAX_BLOCKS);
		end
		return r;
	endfunction

endpackage

// ===== sv/hba_chan_if.sv =====
// valid/ready channel interface carrying one item of type T
interface hba_chan_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== sv/hba_ram.sv =====
// generic single-write, single-read RAM with registered read data
module hba_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 65
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== sv/hba_ctl.sv =====
// controller: sequences tree reads, updates and result hand-off
module hba_ctl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	input  hba_pkg::hba_sts_t sts,
	output hba_pkg::hba_cmd_t cmd
);
	import hba_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD1,
		ST_EV1,
		ST_RD2,
		ST_EV2,
		ST_FIN
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || rsp_ready;

	always_comb begin
		cmd          = '0;
		cmd.capture  = (state_q == ST_IDLE) && req_valid;
		cmd.rd_en    = (state_q == ST_RD1) || (state_q == ST_RD2);
		cmd.lvl2     = (state_q == ST_RD2);
		cmd.ev1      = (state_q == ST_EV1);
		cmd.ev2      = (state_q == ST_EV2);
		cmd.load_out = (state_q == ST_FIN) && slot_free;
	end

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= ST_RD1;
					end
				end
				ST_RD1: begin
					state_q <= ST_EV1;
				end
				ST_EV1: begin
					state_q <= sts.more ? ST_RD2 : ST_FIN;
				end
				ST_RD2: begin
					state_q <= ST_EV2;
				end
				ST_EV2: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule

// ===== sv/hba_dp.sv =====
// datapath: block count, free count, tree word update and lowest-free search
module hba_dp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  hba_pkg::hba_cmd_t         cmd,
	output hba_pkg::hba_sts_t         sts,
	input  logic                      cfg_wr,
	input  logic [hba_pkg::CNT_W-1:0] cfg_data,
	input  hba_pkg::req_item_t        req_data,
	output hba_pkg::rsp_item_t        rsp_data
);
	import hba_pkg::*;

	localparam word_t ONES = '1;

	logic [CNT_W-1:0]      n_q;
	logic [CNT_W-1:0]      free_q;
	mode_t                 mode_q;
	logic [ADDR_W-1:0]     addr_q;
	logic [TREE_DEPTH-1:0] vld_q;
	logic                  rvld_q;
	logic [BIT_W-1:0]      i_q;
	logic                  res_bit_q;
	logic                  res_fnd_q;
	logic [ADDR_W-1:0]     res_faddr_q;
	rsp_item_t             rsp_q;

	logic                  two_lvl;
	logic [WADDR_W-1:0]    n_leaves;
	logic [WADDR_W-1:0]    full_leaves;
	word_t                 last_valid;
	logic                  in_range;
	logic [BIT_W-1:0]      leaf_idx;
	logic [BIT_W-1:0]      bit_idx;
	logic [WADDR_W-1:0]    leaf_w;
	logic [WADDR_W-1:0]    raddr;
	logic [WADDR_W-1:0]    waddr;
	word_t                 rdata;
	word_t                 word;
	word_t                 wdata;
	logic                  we;
	logic                  used;
	logic                  is_mark;
	logic                  chg1;
	word_t                 new1;
	word_t                 full_m;
	logic                  up;
	logic                  chg2;
	word_t                 new2;
	logic                  all1;
	logic [BIT_W-1:0]      zi;
	logic                  fnd1;
	logic                  go2;
	logic [ADDR_W-1:0]     a2;
	logic                  fnd2;

	assign two_lvl     = n_q > CNT_W'(WORD_BITS);
	assign full_leaves = n_q[CNT_W-1:BIT_W];
	assign n_leaves    = full_leaves + WADDR_W'(|n_q[BIT_W-1:0]);
	assign last_valid  = (n_q[BIT_W-1:0] == '0) ? ONES
	                   : ((word_t'(1) << n_q[BIT_W-1:0]) - word_t'(1));

	assign in_range = {1'b0, addr_q} < n_q;
	assign leaf_idx = addr_q[ADDR_W-1:BIT_W];
	assign bit_idx  = addr_q[BIT_W-1:0];
	assign leaf_w   = two_lvl ? (WADDR_W'(leaf_idx) + WADDR_W'(1)) : '0;
	assign used     = (mode_q == MODE_USE);
	assign is_mark  = (mode_q == MODE_USE) || (mode_q == MODE_FREE);

	always_comb begin
		if (mode_q == MODE_FIND) begin
			raddr = cmd.lvl2 ? (WADDR_W'(i_q) + WADDR_W'(1)) : '0;
		end else begin
			raddr = cmd.lvl2 ? '0 : leaf_w;
		end
	end

	assign word = rvld_q ? rdata : '0;

	// leaf level of a mark
	assign chg1   = in_range && is_mark && (word[bit_idx] != used);
	assign new1   = used ? (word | (word_t'(1) << bit_idx)) : (word & ~(word_t'(1) << bit_idx));
	assign full_m = (WADDR_W'(leaf_idx) < full_leaves) ? ONES : last_valid;
	assign up     = chg1 && two_lvl && (!used || (new1 == full_m));

	// root level of a mark
	assign chg2 = word[leaf_idx] != used;
	assign new2 = used ? (word | (word_t'(1) << leaf_idx)) : (word & ~(word_t'(1) << leaf_idx));

	// search
	assign all1 = &word;
	assign zi   = lowest_zero(word);
	assign fnd1 = !all1 && ({{(CNT_W-BIT_W){1'b0}}, zi} < n_q);
	assign go2  = two_lvl && !all1 && (WADDR_W'(zi) < n_leaves);
	assign a2   = {i_q, zi};
	assign fnd2 = !all1 && ({1'b0, a2} < n_q);

	assign sts.more = (mode_q == MODE_FIND) ? go2 : up;
	assign sts.n    = n_q;

	assign we    = (cmd.ev1 && chg1) || (cmd.ev2 && is_mark && chg2);
	assign waddr = cmd.ev2 ? '0 : leaf_w;
	assign wdata = cmd.ev2 ? new2 : new1;

	hba_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (TREE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (cmd.rd_en),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q    <= CNT_W'(MAX_BLOCKS);
			free_q <= CNT_W'(MAX_BLOCKS);
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (cmd.rd_en) begin
				rvld_q <= vld_q[raddr];
			end
			if (cfg_wr) begin
				n_q    <= clamp_count(cfg_data);
				free_q <= clamp_count(cfg_data);
				vld_q  <= '0;
			end else begin
				if (we) begin
					vld_q[waddr] <= 1'b1;
				end
				if (cmd.ev1 && chg1) begin
					free_q <= used ? (free_q - CNT_W'(1)) : (free_q + CNT_W'(1));
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= req_data.mode;
			addr_q <= req_data.block_addr;
		end
		if (cmd.ev1) begin
			i_q         <= zi;
			res_bit_q   <= (mode_q == MODE_READ) && in_range && word[bit_idx];
			res_fnd_q   <= (mode_q == MODE_FIND) && !two_lvl && fnd1;
			res_faddr_q <= ((mode_q == MODE_FIND) && !two_lvl && fnd1) ? ADDR_W'(zi) : '0;
		end
		if (cmd.ev2 && (mode_q == MODE_FIND)) begin
			res_fnd_q   <= fnd2;
			res_faddr_q <= fnd2 ? a2 : '0;
		end
		if (cmd.load_out) begin
			rsp_q.bit_value  <= res_bit_q;
			rsp_q.found      <= res_fnd_q;
			rsp_q.found_addr <= res_faddr_q;
			rsp_q.free_count <= free_q;
		end
	end

	assign rsp_data = rsp_q;
endmodule

// ===== sv/hierarchical_bitmap_allocator.sv =====
// top level of the hierarchical bitmap block allocator
//
//  channel | dir | payload                                    | accepted when
//  req     | in  | mode, block_addr                           | valid && ready
//  rsp     | out | bit_value, found, found_addr, free_count   | valid && ready
//  cfg     | in  | block count (13 bits)                      | valid && ready
//
// each item goes through capture, word read, evaluate and write, and result load;
// with over 64 blocks, a find that descends, a free of a used block or a use that
// fills a leaf also reads and updates a second tree word before the result load
// reset and a block count write clear all word valid bits at once: no sweep
// a finished result sits in the output register; the next item is taken
// meanwhile, and its result waits until that register is free
`include "hierarchical_bitmap_allocator_macros.svh"

module hierarchical_bitmap_allocator (
	input logic       clk,
	input logic       arst_n,
	hba_chan_if.sink   req,
	hba_chan_if.source rsp,
	hba_chan_if.sink   cfg
);
	import hba_pkg::*;

	hba_cmd_t ctl_cmd;
	hba_sts_t dp_sts;
	logic     cfg_wr;

	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid && cfg.ready;

	hba_ctl u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (dp_sts),
		.cmd       (ctl_cmd)
	);

	hba_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (ctl_cmd),
		.sts      (dp_sts),
		.cfg_wr   (cfg_wr),
		.cfg_data (cfg.data),
		.req_data (req.data),
		.rsp_data (rsp.data)
	);

	`HBA_ASSERT_NOW(a_found_has_free, rsp.valid && rsp.data.found, rsp.data.free_count != '0, "found with no free block")
	`HBA_ASSERT_NOW(a_free_in_bounds, rsp.valid, rsp.data.free_count <= dp_sts.n, "free count above block count")
	`HBA_ASSERT_NEXT(a_one_in_flight, req.valid && req.ready, !req.ready, "second item taken while busy")
endmodule
